>>> rtl/pvtc_pkg.sv
// shared types and constants for the projective vertex transform
package pvtc_pkg;
  localparam int FRAC = 16;
  localparam int CW = 32;
  localparam int EW = 32;
  localparam int AW = EW + CW + 2;
  localparam int NREG = 8;
  localparam int IDXW = 4;
  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);

  localparam logic [63:0] CFG_RESET [NREG] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] ndc_x;
    logic signed [31:0] ndc_y;
    logic signed [31:0] ndc_depth;
    logic               in_view;
    logic               w_invalid;
  } ndc_t;

  typedef struct packed {
    logic signed [AW-1:0] hx;
    logic signed [AW-1:0] hy;
    logic signed [AW-1:0] hz;
    logic signed [AW-1:0] hw;
  } hvec_t;

  typedef struct packed {
    logic push;
  } qctl_t;
endpackage

>>> rtl/pvtc_front.sv
// front end: matrix registers, products and homogeneous sums
module pvtc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pvtc_pkg::point_t       in_word,
  input  logic                   cfg_valid,
  input  logic [pvtc_pkg::IDXW-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   q_full,
  output pvtc_pkg::qctl_t        qctl,
  output pvtc_pkg::hvec_t        q_word
);
  import pvtc_pkg::*;

  logic [63:0] regs [NREG];
  logic signed [31:0] m [4][4];
  logic signed [CW-1:0] pt [3];
  logic signed [EW+CW-1:0] p [4][3];
  logic signed [AW-1:0] t [4];
  logic signed [AW-1:0] acc [4];
  logic v1, v2, fe;

  genvar gr, gc;
  generate
    for (gr = 0; gr < 4; gr++) begin : g_row
      for (gc = 0; gc < 4; gc++) begin : g_col
        assign m[gr][gc] = regs[gr*2 + gc/2][(gc%2)*32 +: 32];
      end
    end
  endgenerate

  assign pt[0] = CW'(in_word.point_x);
  assign pt[1] = CW'(in_word.point_y);
  assign pt[2] = CW'(in_word.point_z);

  assign fe = !v2 || !q_full;
  assign in_stall = !fe;
  assign qctl.push = v2 && !q_full;
  assign q_word = '{hx: acc[0], hy: acc[1], hz: acc[2], hw: acc[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) regs[i] <= CFG_RESET[i];
    end else if (cfg_valid && cfg_index < IDXW'(NREG)) begin
      regs[cfg_index[$clog2(NREG)-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (fe) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) p[r][c] <= m[r][c] * pt[c];
        t[r] <= AW'(m[r][3]) <<< FRAC;
        acc[r] <= t[r] + AW'(p[r][0]) + AW'(p[r][1]) + AW'(p[r][2]);
      end
    end
  end
endmodule

>>> rtl/pvtc_queue.sv
// short queue of homogeneous vectors between front and back
module pvtc_queue (
  input  logic            clk,
  input  logic            rst,
  input  pvtc_pkg::qctl_t qctl,
  input  pvtc_pkg::hvec_t wr_word,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output pvtc_pkg::hvec_t rd_word
);
  import pvtc_pkg::*;

  hvec_t mem [QDEPTH];
  logic [QPW-1:0] wp, rp;
  logic [QPW:0] cnt;

  assign full = cnt == (QPW+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign rd_word = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (qctl.push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QPW+1)'(qctl.push) - (QPW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) mem[wp] <= wr_word;
  end
endmodule

>>> rtl/pvtc_back.sv
// back end: magnitudes, clip test and pipelined divide with saturation
module pvtc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            pop,
  input  pvtc_pkg::hvec_t q_word,
  output logic            out_valid,
  input  logic            out_stall,
  output pvtc_pkg::ndc_t  out_word
);
  import pvtc_pkg::*;

  localparam int NS = CW + 1;
  localparam int SH = CW - FRAC;

  logic be;
  logic vld [NS];
  logic [AW-1:0] wm [NS];
  logic [AW-1:0] rem [NS][3];
  logic [CW-1:0] qn [NS][3];
  logic sat [NS][3];
  logic neg [NS][3];
  logic view [NS];
  logic zero [NS];

  logic signed [AW-1:0] a [4];
  logic [AW-1:0] am [4];

  assign be = !out_valid || !out_stall;
  assign pop = be && !q_empty;

  assign a[0] = q_word.hx;
  assign a[1] = q_word.hy;
  assign a[2] = q_word.hz;
  assign a[3] = q_word.hw;

  always_comb begin
    for (int i = 0; i < 4; i++) am[i] = a[i][AW-1] ? AW'(-a[i]) : AW'(a[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (be) begin
      vld[0] <= !q_empty;
      for (int s = 1; s < NS; s++) vld[s] <= vld[s-1];
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      wm[0] <= am[3];
      zero[0] <= a[3] == '0;
      view[0] <= (am[0] <= am[3]) && (am[1] <= am[3]) && (am[2] <= am[3]);
      for (int c = 0; c < 3; c++) begin
        neg[0][c] <= a[c][AW-1] != a[3][AW-1];
        sat[0][c] <= (AW+SH)'(am[c]) >= ((AW+SH)'(am[3]) << SH);
        rem[0][c] <= am[c] >> SH;
        qn[0][c] <= {am[c][SH-1:0], {FRAC{1'b0}}};
      end
    end
  end

  genvar gs;
  generate
    for (gs = 1; gs < NS; gs++) begin : g_div
      logic [AW:0] tr [3];
      logic ge [3];
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          tr[c] = {rem[gs-1][c], qn[gs-1][c][CW-1]};
          ge[c] = tr[c] >= {1'b0, wm[gs-1]};
        end
      end
      always_ff @(posedge clk) begin
        if (be) begin
          wm[gs] <= wm[gs-1];
          zero[gs] <= zero[gs-1];
          view[gs] <= view[gs-1];
          for (int c = 0; c < 3; c++) begin
            neg[gs][c] <= neg[gs-1][c];
            sat[gs][c] <= sat[gs-1][c];
            rem[gs][c] <= ge[c] ? AW'(tr[c] - {1'b0, wm[gs-1]}) : tr[c][AW-1:0];
            qn[gs][c] <= {qn[gs-1][c][CW-2:0], ge[c]};
          end
        end
      end
    end
  endgenerate

  logic [CW-1:0] lim [3];
  logic [CW-1:0] qs [3];
  logic [CW-1:0] val [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lim[c] = neg[NS-1][c] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      qs[c] = (sat[NS-1][c] || qn[NS-1][c] > lim[c]) ? lim[c] : qn[NS-1][c];
      val[c] = zero[NS-1] ? '0 : (neg[NS-1][c] ? CW'(-qs[c]) : qs[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_word.ndc_x <= 32'(signed'(val[0]));
      out_word.ndc_y <= 32'(signed'(val[1]));
      out_word.ndc_depth <= 32'(signed'(val[2]));
      out_word.in_view <= view[NS-1] && !zero[NS-1];
      out_word.w_invalid <= zero[NS-1];
    end
  end
endmodule

>>> rtl/projective_vertex_transform_clip.sv
// top level of the projective vertex transform with clip test
//  channel | direction | handshake             | word
//  in      | in        | in_valid / in_stall   | point_t
//  out     | out       | out_valid / out_stall | ndc_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// one point per cycle sustained while no stall is raised; a point passes the
// front products and sums, the queue, and divide stages of one quotient bit each
// synchronous reset clears the valid chain and queue and loads the reset matrix
// an output stall freezes the back pipeline; the front runs until the queue fills
module projective_vertex_transform_clip (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pvtc_pkg::point_t          in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pvtc_pkg::ndc_t            out_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pvtc_pkg::IDXW-1:0] cfg_index,
  input  logic [63:0]               cfg_data
);
  import pvtc_pkg::*;

  qctl_t qctl;
  hvec_t fq_word, qb_word;
  logic q_full, q_empty, pop;

  assign cfg_ready = 1'b1;

  pvtc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .cfg_valid, .cfg_index, .cfg_data,
    .q_full, .qctl, .q_word(fq_word)
  );

  pvtc_queue u_queue (
    .clk, .rst, .qctl, .wr_word(fq_word),
    .full(q_full), .empty(q_empty), .pop, .rd_word(qb_word)
  );

  pvtc_back u_back (
    .clk, .rst, .q_empty, .pop, .q_word(qb_word),
    .out_valid, .out_stall, .out_word
  );
endmodule

>>> rtl/pvtc_checker.sv
// port-level checker for the projective vertex transform
module pvtc_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input pvtc_pkg::ndc_t out_word,
  input logic           cfg_ready
);
  import pvtc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_winv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.w_invalid |-> !out_word.in_view && out_word.ndc_x == '0
      && out_word.ndc_y == '0 && out_word.ndc_depth == '0)
    else $error("zero w result not cleared");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind projective_vertex_transform_clip pvtc_checker u_pvtc_checker (
  .clk, .rst, .out_valid, .out_stall, .out_word, .cfg_ready
);
